### sv/stpg_pkg.sv
// Shared types and constants for the spiral tail pixel generator.
// Holds the spiral path tables and the pixel request record; no dependencies.
package stpg_pkg;

	localparam int FACES_DEF    = 6;
	localparam int TAIL_LEN_DEF = 14;
	localparam int PATH_LEN     = 64;
	localparam int HEAD_UNIT    = 5120;

	localparam int HEAD_W  = 19;
	localparam int PAUSE_W = 12;
	localparam int HUE_W   = 10;
	localparam int IDX_W   = 6;
	localparam int TI_W    = 5;	// tail index, tails up to 32 cells

	typedef struct packed {
		logic [2:0]       face;
		logic [IDX_W-1:0] idx;
		logic [TI_W-1:0]  tail_i;
		logic [HUE_W-1:0] seed;
		logic             last;
	} pix_req_t;

	localparam logic [2:0] PATH_COL [PATH_LEN] = '{
		3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
		3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7,
		3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0,
		3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
		3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6,
		3'd6, 3'd6, 3'd6, 3'd6, 3'd6,
		3'd5, 3'd4, 3'd3, 3'd2, 3'd1,
		3'd1, 3'd1, 3'd1, 3'd1,
		3'd2, 3'd3, 3'd4, 3'd5,
		3'd5, 3'd5, 3'd5,
		3'd4, 3'd3, 3'd2,
		3'd2, 3'd2,
		3'd3, 3'd4, 3'd4, 3'd3
	};

	localparam logic [2:0] PATH_ROW [PATH_LEN] = '{
		3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
		3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
		3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7,
		3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1,
		3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
		3'd2, 3'd3, 3'd4, 3'd5, 3'd6,
		3'd6, 3'd6, 3'd6, 3'd6, 3'd6,
		3'd5, 3'd4, 3'd3, 3'd2,
		3'd2, 3'd2, 3'd2, 3'd2,
		3'd3, 3'd4, 3'd5,
		3'd5, 3'd5, 3'd5,
		3'd4, 3'd3,
		3'd3, 3'd3, 3'd4, 3'd4
	};

endpackage

### sv/stpg_pix.sv
// Pixel datapath: path lookup, hue to RGB with fading value, output register.
// Depends on stpg_pkg. Three stages, one request per cycle, stalls as a whole.
module stpg_pix
	import stpg_pkg::*;
#(
	parameter int TAIL_LEN = TAIL_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  pix_req_t   req,
	output logic       req_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] face_out,
	output logic [2:0] col,
	output logic [2:0] row,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic       last
);

	localparam int VN_W     = $clog2(TAIL_LEN + 1);
	localparam int RECIP_SH = 19;
	localparam int RECIP_M  = ((1 << RECIP_SH) + TAIL_LEN - 1) / TAIL_LEN;
	localparam int M_W      = RECIP_SH + 1;
	localparam int Y_W      = 13;
	localparam int P_W      = 16;
	localparam int RM_W     = Y_W + M_W;

	logic [7:0] full_tab [2**VN_W];

	for (genvar g = 0; g < 2**VN_W; g++) begin : g_full
		assign full_tab[g] = 8'((255 * g) / TAIL_LEN);
	end

	logic adv;

	// stage 1
	logic [HUE_W-1:0] hue;
	logic [12:0]      t6;
	logic [10:0]      q;
	logic [VN_W-1:0]  vn;

	logic             v_s1;
	logic [2:0]       face_s1, col_s1, row_s1, seg_s1;
	logic [10:0]      q_s1;
	logic [VN_W-1:0]  vn_s1;
	logic             last_s1;

	// stage 2
	logic [P_W-1:0]   pq;
	logic [P_W+7:0]   p255;

	logic             v_s2;
	logic [2:0]       face_s2, col_s2, row_s2, seg_s2;
	logic [Y_W-1:0]   y_s2;
	logic [7:0]       full_s2;
	logic             last_s2;

	// output
	logic [RM_W-1:0]  rm;
	logic [7:0]       ramp;
	logic [7:0]       r_d, g_d, b_d;
	logic             out_valid_q;

	assign adv       = !out_valid_q || out_ready;
	assign req_ready = adv;
	assign out_valid = out_valid_q;

	assign hue = req.seed + {req.idx, 4'b0000};
	assign t6  = 13'({hue, 2'b00}) + 13'({hue, 1'b0});
	assign q   = t6[10] ? (11'd1024 - 11'(t6[9:0])) : 11'(t6[9:0]);
	assign vn  = VN_W'(TAIL_LEN) - VN_W'(req.tail_i);

	assign pq   = P_W'(vn_s1) * P_W'(q_s1);
	assign p255 = {pq, 8'd0} - (P_W+8)'(pq);

	assign rm   = RM_W'(y_s2) * RM_W'(RECIP_M);
	assign ramp = rm[RECIP_SH +: 8];

	always_comb begin
		r_d = '0;
		g_d = '0;
		b_d = '0;
		unique case (seg_s2)
			3'd0: begin
				r_d = full_s2;
				g_d = ramp;
			end
			3'd1: begin
				r_d = ramp;
				g_d = full_s2;
			end
			3'd2: begin
				g_d = full_s2;
				b_d = ramp;
			end
			3'd3: begin
				g_d = ramp;
				b_d = full_s2;
			end
			3'd4: begin
				r_d = ramp;
				b_d = full_s2;
			end
			default: begin
				r_d = full_s2;
				b_d = ramp;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= req_valid;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			face_s1  <= req.face;
			col_s1   <= PATH_COL[req.idx];
			row_s1   <= PATH_ROW[req.idx];
			seg_s1   <= t6[12:10];
			q_s1     <= q;
			vn_s1    <= vn;
			last_s1  <= req.last;

			face_s2  <= face_s1;
			col_s2   <= col_s1;
			row_s2   <= row_s1;
			seg_s2   <= seg_s1;
			y_s2     <= p255[10 +: Y_W];
			full_s2  <= full_tab[vn_s1];
			last_s2  <= last_s1;

			face_out <= face_s2;
			col      <= col_s2;
			row      <= row_s2;
			red      <= r_d;
			green    <= g_d;
			blue     <= b_d;
			last     <= last_s2;
		end
	end

endmodule

### sv/spiral_tail_pixel_generator_core.sv
// Each accepted tick reads its face state from one memory, updates and writes it back
// (S_RD), launches (S_LAUNCH) and issues pixel requests (S_EMIT) to stpg_pix. A face
// out of range is dropped in S_IDLE; a paused or ending face stops after S_RD; n tail
// pixels (n <= TAIL_LEN) go one per cycle unless stpg_pix stalls, all before a new tick.
// Reset: control state clears and config registers take their defaults at once; face
// entries read as their reset values until first written.
module spiral_tail_pixel_generator_core
	import stpg_pkg::*;
#(
	parameter int FACES    = FACES_DEF,
	parameter int TAIL_LEN = TAIL_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  face,
	input  logic [9:0]  elapsed,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  face_out,
	output logic [2:0]  col,
	output logic [2:0]  row,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	localparam int FA_W   = (FACES > 1) ? $clog2(FACES) : 1;
	localparam int CELL_W = 7;
	localparam logic [HEAD_W:0]   HEAD_END = (HEAD_W+1)'((PATH_LEN + TAIL_LEN) * HEAD_UNIT);
	localparam logic [HEAD_W-1:0] HEAD_SAT = '1;
	localparam logic [CELL_W-1:0] PATH_TOP = CELL_W'(PATH_LEN - 1);
	localparam logic [CELL_W-1:0] TAIL_TOP = CELL_W'(TAIL_LEN - 1);

	typedef enum logic [1:0] {CFG_SPEED, CFG_PAUSE, CFG_HUE} cfg_idx_t;
	typedef enum logic [1:0] {S_IDLE, S_RD, S_LAUNCH, S_EMIT} state_t;

	typedef struct packed {
		logic [HEAD_W-1:0]  head;
		logic [PAUSE_W-1:0] pause;
		logic [HUE_W-1:0]   hue;
	} ent_t;

	ent_t mem [FACES];
	ent_t rd_q, cur, rst_ent, wr_ent;

	state_t            state_q;
	logic [FACES-1:0]  vld_q;
	logic [7:0]        speed_q;
	logic [PAUSE_W-1:0] pause_cfg_q;
	logic [HUE_W-1:0]  hue_step_q;
	logic [2:0]        face_q;
	logic [9:0]        el_q;
	logic [HEAD_W-1:0] prod_q, head_q;
	logic [HUE_W-1:0]  seed_q;
	logic [CELL_W-1:0] cell_q;
	logic [TI_W-1:0]   i_q, i_end_q;

	logic              in_fire, face_ok, rd_en, wr_en;
	logic [8:0]        speed_sum;
	logic [HEAD_W:0]   head_sum;
	logic [HEAD_W-1:0] head_sat;
	logic              at_end, pause_hit, go_launch;
	logic [16:0]       cell_mul;
	logic [CELL_W-1:0] head_cell, i_start, i_end;
	logic              tail_empty;
	logic              req_valid, req_ready;
	pix_req_t          req;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign face_ok   = {1'b0, face} < 4'(FACES);
	assign rd_en     = in_fire && face_ok;
	assign wr_en     = (state_q == S_RD);
	assign cfg_ready = 1'b1;
	assign speed_sum = 9'd75 + {1'b0, speed_q};

	// state store
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_q <= mem[face[FA_W-1:0]];
		if (wr_en)
			mem[face_q[FA_W-1:0]] <= wr_ent;
	end

	assign rst_ent.head  = HEAD_W'(32'(face_q) * (13 * HEAD_UNIT));
	assign rst_ent.pause = '0;
	assign rst_ent.hue   = HUE_W'(32'(face_q) * 164);
	assign cur = vld_q[face_q[FA_W-1:0]] ? rd_q : rst_ent;

	assign head_sum  = {1'b0, cur.head} + {1'b0, prod_q};
	assign head_sat  = head_sum[HEAD_W] ? HEAD_SAT : head_sum[HEAD_W-1:0];
	assign at_end    = {1'b0, head_sat} >= HEAD_END;
	assign pause_hit = {2'b00, el_q} >= cur.pause;
	assign go_launch = (cur.pause == '0) && !at_end;

	always_comb begin
		wr_ent = cur;
		if (cur.pause != '0) begin
			if (pause_hit) begin
				wr_ent.pause = '0;
				wr_ent.head  = '0;
				wr_ent.hue   = cur.hue + hue_step_q;
			end else begin
				wr_ent.pause = cur.pause - PAUSE_W'(el_q);
			end
		end else begin
			wr_ent.head = head_sat;
			if (at_end)
				wr_ent.pause = (pause_cfg_q == '0) ? PAUSE_W'(1) : pause_cfg_q;
		end
	end

	// head cell = head / 5120, as (head >> 10) / 5 by reciprocal
	assign cell_mul   = 17'(head_q[HEAD_W-1:10]) * 17'd205;
	assign head_cell  = cell_mul[16:10];
	assign i_start    = (head_cell > PATH_TOP) ? (head_cell - PATH_TOP) : '0;
	assign i_end      = (head_cell < TAIL_TOP) ? head_cell : TAIL_TOP;
	assign tail_empty = i_start > i_end;

	assign req_valid   = (state_q == S_EMIT);
	assign req.face    = face_q;
	assign req.idx     = IDX_W'(cell_q - CELL_W'(i_q));
	assign req.tail_i  = i_q;
	assign req.seed    = seed_q;
	assign req.last    = (i_q == i_end_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q     <= 8'd128;
			pause_cfg_q <= PAUSE_W'(358);
			hue_step_q  <= HUE_W'(174);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SPEED: speed_q     <= cfg_data[7:0];
				CFG_PAUSE: pause_cfg_q <= cfg_data[PAUSE_W-1:0];
				CFG_HUE:   hue_step_q  <= cfg_data[HUE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vld_q   <= '0;
			face_q  <= '0;
			el_q    <= '0;
			prod_q  <= '0;
			head_q  <= '0;
			seed_q  <= '0;
			cell_q  <= '0;
			i_q     <= '0;
			i_end_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (rd_en) begin
						face_q  <= face;
						el_q    <= elapsed;
						prod_q  <= HEAD_W'(19'(elapsed) * 19'(speed_sum));
						state_q <= S_RD;
					end
				end
				S_RD: begin
					vld_q[face_q[FA_W-1:0]] <= 1'b1;
					head_q  <= head_sat;
					seed_q  <= cur.hue;
					state_q <= go_launch ? S_LAUNCH : S_IDLE;
				end
				S_LAUNCH: begin
					cell_q  <= head_cell;
					i_q     <= i_start[TI_W-1:0];
					i_end_q <= i_end[TI_W-1:0];
					state_q <= tail_empty ? S_IDLE : S_EMIT;
				end
				S_EMIT: begin
					if (req_ready) begin
						if (req.last)
							state_q <= S_IDLE;
						else
							i_q <= i_q + TI_W'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	stpg_pix #(
		.TAIL_LEN (TAIL_LEN)
	) u_pix (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_ready (req_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.face_out  (face_out),
		.col       (col),
		.row       (row),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.last      (last)
	);

endmodule
